[rtl/core/tcpe_pkg.sv]
// Shared types and constants for the text console put engine.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package tcpe_pkg;

	// Operation codes carried in the command transaction.
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Character codes with a cursor meaning.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7F;

	localparam int TAB_STEP = 8;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'd1;
	localparam logic [3:0] FORE_RST = 4'hF;
	localparam logic [3:0] BACK_RST = 4'h0;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [4:0] screen_row;
		logic [6:0] screen_col;
	} cmd_item_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [4:0]  top_ring_row;
		logic [15:0] cell_value;
	} res_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [3:0]           value;
	} cfg_item_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

endpackage

[rtl/core/tcpe_if.sv]
// Valid/ready channel interfaces for the text console put engine.
// Depends on tcpe_pkg for the payload types.
`timescale 1ns / 1ps

interface tcpe_cmd_if;
	logic                valid;
	logic                ready;
	tcpe_pkg::cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcpe_res_if;
	logic                valid;
	logic                ready;
	tcpe_pkg::res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcpe_cfg_if;
	logic                valid;
	logic                ready;
	tcpe_pkg::cfg_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tcpe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module tcpe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/text_console_put_engine.sv]
// Top level of the text console put engine: cursor control, scroll and clear
// sequencing around one cell RAM. Depends on tcpe_pkg, tcpe_if and tcpe_ram.
`timescale 1ns / 1ps

// Usage:
// Commands arrive on the cmd channel; each accepted transaction yields exactly
// one transaction on the res channel with the cursor position, the ring row
// shown at the top of the screen and, for a read, the addressed cell.
// The cfg channel writes the foreground and background color nibbles; it is
// always ready and should only be used while no command is in progress.
// Command sequence, one command at a time:
//   put without scroll, read, unused op: accept, then result.
//   put that scrolls: accept, blank the new bottom row one cell per cycle
//     through the single RAM write port, then result.
//   clear: accept, the same port walking every cell, then result.
// After reset the engine writes blank cells (attribute 0x0F) into every RAM
// cell; cmd.ready stays low during that pass.
// Results sit in an output register. When the receiver stalls, the engine
// finishes the current command and then holds it until the register frees;
// the next command can be accepted while an earlier result is still waiting.
// A read issues the RAM access in the accept cycle and picks the data off the
// registered RAM output in the result cycle.

module text_console_put_engine #(
	parameter int COLUMNS   = 80,
	parameter int ROW_COUNT = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	tcpe_cmd_if.sink      cmd,
	tcpe_res_if.source    res,
	tcpe_cfg_if.sink      cfg
);

	localparam int CELLS = ROW_COUNT * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int NC_W  = COL_W + 1;
	localparam int ROW_W = $clog2(ROW_COUNT);

	tcpe_pkg::state_t state_q, state_d;

	logic [COL_W-1:0] cursor_col_q;
	logic [ROW_W-1:0] cursor_row_q;
	logic [ROW_W-1:0] ring_q;
	logic [3:0]       fore_q;
	logic [3:0]       back_q;

	// Sweep engine shared by the reset pass, clear and scroll blanking.
	logic [AW-1:0]    sweep_addr_q;
	logic [AW-1:0]    sweep_end_q;
	logic [15:0]      fill_q;

	logic             rd_q;
	logic             out_valid_q;
	tcpe_pkg::res_item_t out_q;

	logic             cmd_acc;
	logic [7:0]       attr;
	logic [15:0]      blank;
	logic [NC_W-1:0]  col_ext;
	logic [NC_W-1:0]  nc;
	logic             printable;
	logic             wrap;
	logic             at_bottom;
	logic [ROW_W-1:0] ring_inc;
	logic [ROW_W-1:0] top_row;
	logic [AW-1:0]    char_addr;
	logic [AW-1:0]    scroll_base;
	logic             rd_ok;
	logic [ROW_W:0]   rr_sum;
	logic [ROW_W-1:0] rr;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    pos;
	logic             load_out;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [15:0]      ram_wdata;
	logic             ram_re;
	logic [15:0]      ram_rdata;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == tcpe_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;

	assign attr  = {back_q, fore_q};
	assign blank = {attr, tcpe_pkg::CH_SPACE};

	// Cursor arithmetic for a put. The new column is one bit wider so that a
	// tab or advance past the last column is seen before it wraps.
	assign col_ext   = {1'b0, cursor_col_q};
	assign printable = cmd.data.ch inside {[tcpe_pkg::CH_SPACE:tcpe_pkg::CH_LAST]};

	always_comb begin
		case (cmd.data.ch)
			tcpe_pkg::CH_BS: begin
				nc = (cursor_col_q != '0) ? col_ext - 1'b1 : col_ext;
			end
			tcpe_pkg::CH_TAB: begin
				nc = (col_ext + NC_W'(tcpe_pkg::TAB_STEP)) & ~NC_W'(tcpe_pkg::TAB_STEP - 1);
			end
			tcpe_pkg::CH_CR: begin
				nc = '0;
			end
			default: begin
				nc = printable ? col_ext + 1'b1 : col_ext;
			end
		endcase
	end

	// A line feed always starts a new line; anything else does when the
	// column runs off the right edge.
	assign wrap      = (cmd.data.ch == tcpe_pkg::CH_LF) || (nc >= NC_W'(COLUMNS));
	assign at_bottom = (cursor_row_q == ROW_W'(ROW_COUNT - 1));
	assign ring_inc  = (ring_q == ROW_W'(ROW_COUNT - 1)) ? '0 : ring_q + 1'b1;
	assign top_row   = at_bottom ? ring_inc : '0;

	assign char_addr   = AW'(ring_q) * AW'(COLUMNS) + AW'(cursor_col_q);
	assign scroll_base = AW'(ring_inc) * AW'(COLUMNS);

	// Displayed row to ring row: both terms are below ROW_COUNT, so one
	// conditional subtract is the whole modulo.
	assign rd_ok  = ({2'b0, cmd.data.screen_row} < 7'(ROW_COUNT)) &&
	                ({1'b0, cmd.data.screen_col} < 8'(COLUMNS));
	assign rr_sum = {1'b0, top_row} + (ROW_W + 1)'(cmd.data.screen_row);
	assign rr     = (rr_sum >= (ROW_W + 1)'(ROW_COUNT)) ?
	                ROW_W'(rr_sum - (ROW_W + 1)'(ROW_COUNT)) : ROW_W'(rr_sum);
	assign rd_addr = AW'(rr) * AW'(COLUMNS) + AW'(cmd.data.screen_col);

	// Result fields come from the already updated cursor registers.
	assign pos = AW'(cursor_row_q) * AW'(COLUMNS) + AW'(cursor_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpe_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = sweep_addr_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			tcpe_pkg::ST_INIT: begin
				ram_we = 1'b1;
				if (sweep_addr_q == sweep_end_q) begin
					state_d = tcpe_pkg::ST_IDLE;
				end
			end
			tcpe_pkg::ST_SWEEP: begin
				ram_we = 1'b1;
				if (sweep_addr_q == sweep_end_q) begin
					state_d = tcpe_pkg::ST_DONE;
				end
			end
			tcpe_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd.data.op)
						tcpe_pkg::OP_PUT: begin
							ram_we    = printable;
							ram_waddr = char_addr;
							ram_wdata = {attr, cmd.data.ch};
							state_d   = (wrap && at_bottom) ? tcpe_pkg::ST_SWEEP
							                                : tcpe_pkg::ST_DONE;
						end
						tcpe_pkg::OP_CLEAR: begin
							state_d = tcpe_pkg::ST_SWEEP;
						end
						tcpe_pkg::OP_READ: begin
							ram_re  = rd_ok;
							state_d = tcpe_pkg::ST_DONE;
						end
						default: begin
							state_d = tcpe_pkg::ST_DONE;
						end
					endcase
				end
			end
			tcpe_pkg::ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					load_out = 1'b1;
					state_d  = tcpe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcpe_pkg::ST_IDLE;
			end
		endcase
	end

	// Cursor, ring, colors, the sweep bounds, the read flag and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			ring_q       <= '0;
			fore_q       <= tcpe_pkg::FORE_RST;
			back_q       <= tcpe_pkg::BACK_RST;
			sweep_addr_q <= '0;
			sweep_end_q  <= AW'(CELLS - 1);
			fill_q       <= {tcpe_pkg::BACK_RST, tcpe_pkg::FORE_RST, tcpe_pkg::CH_SPACE};
			rd_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					tcpe_pkg::REG_FORE: fore_q <= cfg.data.value;
					tcpe_pkg::REG_BACK: back_q <= cfg.data.value;
					default: ;
				endcase
			end

			if ((state_q == tcpe_pkg::ST_INIT || state_q == tcpe_pkg::ST_SWEEP) &&
			    sweep_addr_q != sweep_end_q) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end

			if (cmd_acc) begin
				rd_q <= (cmd.data.op == tcpe_pkg::OP_READ) && rd_ok;
				case (cmd.data.op)
					tcpe_pkg::OP_PUT: begin
						if (wrap) begin
							cursor_col_q <= '0;
							ring_q       <= ring_inc;
							if (at_bottom) begin
								// Scroll: the ring row now at the bottom is blanked.
								sweep_addr_q <= scroll_base;
								sweep_end_q  <= scroll_base + AW'(COLUMNS - 1);
								fill_q       <= blank;
							end else begin
								cursor_row_q <= cursor_row_q + 1'b1;
							end
						end else begin
							cursor_col_q <= COL_W'(nc);
						end
					end
					tcpe_pkg::OP_CLEAR: begin
						cursor_col_q <= '0;
						cursor_row_q <= '0;
						ring_q       <= '0;
						sweep_addr_q <= '0;
						sweep_end_q  <= AW'(CELLS - 1);
						fill_q       <= blank;
					end
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.cursor_position <= 11'(pos);
			out_q.top_ring_row    <= 5'(top_row);
			out_q.cell_value      <= rd_q ? ram_rdata : 16'h0000;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	tcpe_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// The reset clearing pass is entered only through reset.
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tcpe_pkg::ST_INIT |=> state_q != tcpe_pkg::ST_INIT)
		else $error("clearing pass re-entered");

	// Cursor and ring stay on the screen between commands.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_col_q} < NC_W'(COLUMNS)) &&
		({1'b0, cursor_row_q} < (ROW_W + 1)'(ROW_COUNT)) &&
		({1'b0, ring_q} < (ROW_W + 1)'(ROW_COUNT)))
		else $error("cursor or ring row out of range");

	// An accepted command always leaves idle until its result is loaded.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> state_q != tcpe_pkg::ST_IDLE)
		else $error("command accepted without being processed");

	// A result appears only when a command completes.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tcpe_pkg::ST_DONE))
		else $error("result loaded outside command completion");

endmodule
